// File: hw/rtl/xed_pkg.sv
// Types, constants and entity tables shared by the XML entity decoder modules.
package xed_pkg;

  localparam int MAX_RES = 6;
  localparam int ENT_N   = 5;

  localparam logic [15:0] LIMIT_RST = 16'd1024;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  // entity names after '&', zero padded
  localparam logic [7:0] ENT_TEXT [ENT_N][ENT_N] = '{
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // amp;
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // lt;
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // gt;
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // quot;
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}   // apos;
  };
  localparam logic [7:0] ENT_VAL [ENT_N] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};

  typedef enum logic [1:0] {
    PH_WAIT = 2'b01,
    PH_RUN  = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
    logic       end_of_input;
  } xed_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        done_res;
    logic [15:0] length;
  } xed_out_t;

  typedef xed_out_t [MAX_RES-1:0] xed_res_vec_t;

  typedef struct packed {
    phase_t      phase;
    logic        in_entity;
    logic [4:0]  cand;
    logic [2:0]  held_count;
    logic [15:0] emitted;
  } xed_state_t;

  typedef struct packed {
    logic [2:0] nres;
    xed_state_t st_nxt;
    logic       hold_we;
    logic [1:0] hold_idx;
    logic [7:0] hold_byte;
  } xed_step_t;

endpackage

// File: hw/rtl/xed_decode.sv
// Per-byte decode step: result list and next decoder state for one input transfer.
module xed_decode import xed_pkg::*; (
  input  xed_state_t       st,
  input  logic [3:0][7:0]  held,
  input  xed_in_t          item,
  input  logic [15:0]      limit,
  output xed_step_t        step,
  output xed_res_vec_t     res
);

  logic [7:0]  b;
  logic        start;
  logic        last;
  logic        active;
  logic [15:0] max_b;
  logic [15:0] cnt0;
  logic        ent0;
  logic [4:0]  cand0;
  logic [2:0]  hc0;
  logic        is_stop;
  logic        quote_skip;
  logic [4:0]  m;
  logic [2:0]  sel;
  logic        semi_hit;
  logic        letter_hold;

  logic        flush;
  logic [2:0]  fl_hc;
  logic        extra_vld;
  logic [7:0]  extra;
  logic        single;
  logic [7:0]  single_byte;
  logic        free;
  logic        term;
  logic        ent_n;
  logic [4:0]  cand_n;
  logic [2:0]  hc_n;

  logic [MAX_RES-1:0][7:0] lst;
  logic [4:0][7:0] base;
  logic [2:0]  n;
  logic [16:0] room17;
  logic [15:0] room;
  logic [2:0]  e;
  logic        pf;
  logic        ended;
  logic [15:0] cnt_n;
  logic [2:0]  nres;

  assign b      = item.in_byte;
  assign start  = item.start_req;
  assign last   = item.end_of_input;
  assign active = start || (st.phase == PH_RUN);
  assign max_b  = (limit == '0) ? '0 : limit - 16'd1;
  assign cnt0   = start ? '0 : st.emitted;
  assign ent0   = start ? 1'b0 : st.in_entity;
  assign cand0  = start ? '0 : st.cand;
  assign hc0    = start ? '0 : st.held_count;

  assign is_stop = (b == CH_NUL) || (b == CH_LT) || (b == CH_GT) ||
                   (b == CH_APOS) || (b == CH_QUOT);
  assign quote_skip = start && ((b == CH_APOS) || (b == CH_QUOT));

  always_comb begin
    m   = '0;
    sel = '0;
    for (int i = 0; i < ENT_N; i++) begin
      if (hc0 < 3'(ENT_N)) begin
        m[i] = cand0[i] && (ENT_TEXT[i][hc0] == b) && (b != CH_NUL);
      end
    end
    for (int i = ENT_N - 1; i >= 0; i--) begin
      if (m[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign semi_hit    = ent0 && (b == CH_SEMI) && (m != '0);
  assign letter_hold = ent0 && !semi_hit && (m != '0) && (hc0 < 3'd4);

  always_comb begin
    flush       = 1'b0;
    fl_hc       = '0;
    extra_vld   = 1'b0;
    extra       = b;
    single      = 1'b0;
    single_byte = b;
    free        = 1'b0;
    term        = 1'b0;
    ent_n       = ent0;
    cand_n      = cand0;
    hc_n        = hc0;
    if (!active) begin
      term = 1'b0;
    end else if (quote_skip) begin
      term = (max_b == '0);
    end else if (!ent0) begin
      if ((cnt0 >= max_b) || is_stop) begin
        term = 1'b1;
      end else if (b == CH_AMP) begin
        ent_n  = 1'b1;
        cand_n = 5'h1F;
        hc_n   = '0;
        if (last) begin
          flush = 1'b1;
          free  = 1'b1;
        end
      end else begin
        single = 1'b1;
      end
    end else if (semi_hit) begin
      single      = 1'b1;
      single_byte = ENT_VAL[sel];
      free        = 1'b1;
      ent_n       = 1'b0;
      cand_n      = '0;
      hc_n        = '0;
    end else if (letter_hold) begin
      hc_n   = hc0 + 3'd1;
      cand_n = m;
      if (last) begin
        flush     = 1'b1;
        fl_hc     = hc0;
        extra_vld = 1'b1;
        free      = 1'b1;
      end
    end else begin
      // failed prefix: replay '&' and held letters, then handle byte afresh
      flush  = 1'b1;
      fl_hc  = hc0;
      free   = 1'b1;
      ent_n  = 1'b0;
      cand_n = '0;
      hc_n   = '0;
      if (is_stop) begin
        term = 1'b1;
      end else if (b == CH_AMP) begin
        ent_n  = 1'b1;
        cand_n = 5'h1F;
        if (last) begin
          extra_vld = 1'b1;
          extra     = CH_AMP;
        end
      end else begin
        extra_vld = 1'b1;
      end
    end
  end

  assign base = {held[3], held[2], held[1], held[0], CH_AMP};

  always_comb begin
    lst = '0;
    if (single) begin
      lst[0] = single_byte;
    end else begin
      for (int k = 0; k < 5; k++) begin
        lst[k] = (3'(k) <= fl_hc) ? base[k] : extra;
      end
      lst[MAX_RES-1] = extra;
    end
  end

  assign n = single ? 3'd1 : (flush ? (3'd1 + fl_hc + {2'b0, extra_vld}) : 3'd0);

  assign room17 = {1'b0, max_b} - {1'b0, cnt0};
  assign room   = room17[16] ? '0 : room17[15:0];

  always_comb begin
    if (n == '0) begin
      e = '0;
    end else if (room >= {13'b0, n}) begin
      e = n;
    end else if (room == '0) begin
      e = free ? 3'd1 : 3'd0;
    end else begin
      e = room[2:0];
    end
  end

  assign pf    = (e != '0) && ({13'b0, e} >= room);
  assign ended = active && (pf || term || last);
  assign cnt_n = cnt0 + {13'b0, e};
  assign nres  = (ended && (e == '0)) ? 3'd1 : e;

  always_comb begin
    step.nres      = nres;
    step.hold_we   = active && letter_hold;
    step.hold_idx  = hc0[1:0];
    step.hold_byte = b;
    if (!active) begin
      step.st_nxt = st;
    end else if (ended) begin
      step.st_nxt.phase      = PH_WAIT;
      step.st_nxt.in_entity  = 1'b0;
      step.st_nxt.cand       = '0;
      step.st_nxt.held_count = '0;
      step.st_nxt.emitted    = cnt_n;
    end else begin
      step.st_nxt.phase      = PH_RUN;
      step.st_nxt.in_entity  = ent_n;
      step.st_nxt.cand       = cand_n;
      step.st_nxt.held_count = hc_n;
      step.st_nxt.emitted    = cnt_n;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      res[k].has_byte = (3'(k) < e);
      res[k].out_byte = (3'(k) < e) ? lst[k] : '0;
      res[k].done_res = ended && (3'(k) == nres - 3'd1);
      res[k].length   = (ended && (3'(k) == nres - 3'd1)) ? cnt_n : '0;
    end
  end

endmodule

// File: hw/rtl/xed_res_buf.sv
// Result buffer: holds one byte's results, sends one per cycle while out_ready is high.
module xed_res_buf import xed_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  logic [2:0]   load_n,
  input  xed_res_vec_t load_res,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output xed_out_t     out_data
);

  xed_res_vec_t res_r;
  logic [2:0]   cnt_r;
  logic [2:0]   idx_r;
  logic         vld_r;
  logic         take;
  logic         last_take;

  assign take      = vld_r && out_ready;
  assign last_take = take && (idx_r == cnt_r - 3'd1);
  assign free      = !vld_r || last_take;
  assign out_valid = vld_r;
  assign out_data  = res_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load && free) begin
      vld_r <= (load_n != '0);
      cnt_r <= load_n;
      idx_r <= '0;
    end else if (last_take) begin
      vld_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= load_res;
    end
  end

endmodule

// File: hw/rtl/xml_entity_decoder_top.sv
// XML predefined-entity decoder top: input register, decoder state, config, result buffer.
//
// Decodes a quoted or bare XML value one byte per input transfer, turning &amp; &lt; &gt;
// &quot; &apos; into single bytes and ending at a markup or quote byte, a zero byte, the
// end_of_input byte or once out_limit-1 bytes are out; the last result carries done_res
// and the length. An input byte is registered, decoded combinationally and its result list
// (zero to six results) is loaded into the result buffer, which sends one result per cycle
// while out_ready is high, so plain text then runs at one byte per cycle; a byte that gives
// several results holds the input side until all are sent (a failed entity prefix replays
// '&' and up to four letters). out_limit is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while idle, as the block itself does not enforce this.
module xml_entity_decoder_top import xed_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  xed_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output xed_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  xed_in_t         in_data_r;
  logic            in_vld_r;
  xed_state_t      st_r;
  xed_state_t      st_nxt;
  logic [3:0][7:0] held_r;
  logic [15:0]     limit_r;
  xed_step_t       step;
  xed_res_vec_t    res;
  logic            buf_free;
  logic            move;

  assign move     = in_vld_r && buf_free;
  assign in_ready = !in_vld_r || move;
  assign st_nxt   = move ? step.st_nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (move) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '{phase: PH_WAIT, in_entity: 1'b0, cand: '0, held_count: '0, emitted: '0};
      limit_r <= LIMIT_RST;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move && step.hold_we) begin
      held_r[step.hold_idx] <= step.hold_byte;
    end
  end

  xed_decode u_decode (
    .st    (st_r),
    .held  (held_r),
    .item  (in_data_r),
    .limit (limit_r),
    .step  (step),
    .res   (res)
  );

  xed_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move),
    .load_n    (step.nres),
    .load_res  (res),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a result without a byte is always the closing one
  a_nobyte_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_byte) |-> out_data.done_res)
    else $error("byte-less result without done");

  a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.done_res) |-> (out_data.length == '0))
    else $error("length on non-final result");

  a_entity_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_entity |-> ((st_r.held_count == '0) && (st_r.cand == '0)))
    else $error("entity state left outside entity");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held_count <= 3'd4)
    else $error("held count out of range");

endmodule

// File: bench/xml_entity_decoder_top_test.sv
// Testbench for xml_entity_decoder_top: directed and random strings checked by a scoreboard.
`timescale 1ns / 100ps

module xml_entity_decoder_top_test;
  import xed_pkg::*;

  class entity_scoreboard;
    logic [15:0] out_limit;
    phase_t      phase;
    logic [7:0]  held [4];
    int unsigned held_n;
    logic [4:0]  cand;
    bit          in_ent;
    logic [15:0] emitted;
    bit          ended;
    xed_out_t    step_q [$];
    xed_out_t    pending [$];
    int          errors;

    function new();
      out_limit = LIMIT_RST;
      phase = PH_WAIT;
      held_n = 0;
      cand = '0;
      in_ent = 0;
      emitted = '0;
      errors = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function int unsigned cap();
      return (out_limit == 0) ? 0 : out_limit - 1;
    endfunction

    function void end_string();
      phase = PH_WAIT;
      in_ent = 0;
      cand = '0;
      held_n = 0;
      ended = 1;
    endfunction

    function void emit(logic [7:0] b);
      xed_out_t r;
      if (phase != PH_RUN || step_q.size() >= MAX_RES) return;
      r = '0;
      r.out_byte = b;
      r.has_byte = 1'b1;
      step_q.push_back(r);
      emitted = emitted + 16'd1;
      if (emitted >= cap()) end_string();
    endfunction

    function void plain(logic [7:0] b);
      if (phase != PH_RUN) return;
      if (emitted >= cap() || b == CH_NUL || b == CH_LT || b == CH_GT ||
          b == CH_APOS || b == CH_QUOT) begin
        end_string();
        return;
      end
      if (b == CH_AMP) begin
        in_ent = 1;
        cand = 5'h1F;
        held_n = 0;
        return;
      end
      emit(b);
    endfunction

    // failed entity: '&' and the held letters go out as text
    function void replay();
      int unsigned n;
      n = held_n;
      in_ent = 0;
      cand = '0;
      held_n = 0;
      emit(CH_AMP);
      for (int i = 0; i < n && i < 4; i++) emit(held[i]);
    endfunction

    function void entity_char(logic [7:0] b);
      int unsigned pos;
      logic [4:0] hits;
      pos = held_n;
      hits = '0;
      if (pos < ENT_N) begin
        for (int i = 0; i < ENT_N; i++) begin
          if (cand[i] && ENT_TEXT[i][pos] == b && b != CH_NUL) begin
            if (b == CH_SEMI) begin
              in_ent = 0;
              cand = '0;
              held_n = 0;
              emit(ENT_VAL[i]);
              return;
            end
            hits[i] = 1'b1;
          end
        end
      end
      if (hits != 0 && pos < 4) begin
        held[pos] = b;
        held_n = pos + 1;
        cand = hits;
        return;
      end
      replay();
      plain(b);
    endfunction

    function void decode_byte(xed_in_t t);
      xed_out_t r;
      step_q.delete();
      ended = 0;
      if (t.start_req) begin
        phase = PH_RUN;
        held_n = 0;
        cand = '0;
        in_ent = 0;
        emitted = '0;
        if (t.in_byte == CH_APOS || t.in_byte == CH_QUOT) begin
          if (emitted >= cap()) end_string();
        end else begin
          plain(t.in_byte);
        end
      end else if (phase != PH_RUN) begin
        return;
      end else if (in_ent) begin
        entity_char(t.in_byte);
      end else begin
        plain(t.in_byte);
      end
      if (t.end_of_input && phase == PH_RUN) begin
        if (in_ent) replay();
        if (phase == PH_RUN) end_string();
      end
      if (ended) begin
        if (step_q.size() == 0) begin
          r = '0;
          step_q.push_back(r);
        end
        r = step_q[step_q.size() - 1];
        r.done_res = 1'b1;
        r.length = emitted;
        step_q[step_q.size() - 1] = r;
      end
      foreach (step_q[i]) pending.push_back(step_q[i]);
    endfunction

    task report(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_output(xed_out_t r);
      xed_out_t e;
      if (pending.size() == 0) begin
        report("result with none expected", int'(r.out_byte), 0);
        return;
      end
      e = pending.pop_front();
      if (r.out_byte !== e.out_byte)
        report("out_byte", int'(r.out_byte), int'(e.out_byte));
      if (r.has_byte !== e.has_byte)
        report("has_byte", int'(r.has_byte), int'(e.has_byte));
      if (r.done_res !== e.done_res)
        report("done_res", int'(r.done_res), int'(e.done_res));
      if (r.length !== e.length) report("length", int'(r.length), int'(e.length));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  xed_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  xed_out_t    out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  entity_scoreboard sb = new();
  xed_in_t feed_q [$];
  bit tx_fast = 0;
  bit rx_fast = 0;
  bit long_hold = 0;

  xml_entity_decoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b, bit st, bit last);
    xed_in_t t;
    t.in_byte = b;
    t.start_req = st;
    t.end_of_input = last;
    feed_q.push_back(t);
  endfunction

  function automatic void add_text(string s, bit last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == 0, last && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return CH_SEMI;
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] stop_char();
    case ($urandom_range(0, 4))
      0: return CH_NUL;
      1: return CH_LT;
      2: return CH_GT;
      3: return CH_APOS;
      default: return CH_QUOT;
    endcase
  endfunction

  // mostly well-formed values: optional quote, text, entities, broken entities
  function automatic void build_string();
    logic [7:0] chars [$];
    int e, n_let, len, mode;
    if ($urandom_range(0, 7) == 0) begin
      add_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      return;
    end
    if ($urandom_range(0, 2) == 0) chars.push_back($urandom_range(0, 1) ? CH_APOS : CH_QUOT);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 5))
        0, 1: chars.push_back(text_char());
        2: begin
          e = $urandom_range(0, ENT_N - 1);
          chars.push_back(CH_AMP);
          for (int k = 0; k < ENT_N && ENT_TEXT[e][k] != CH_NUL; k++)
            chars.push_back(ENT_TEXT[e][k]);
        end
        3: begin
          e = $urandom_range(0, ENT_N - 1);
          n_let = 0;
          while (ENT_TEXT[e][n_let] != CH_SEMI) n_let++;
          len = $urandom_range(0, n_let);
          chars.push_back(CH_AMP);
          for (int k = 0; k < len; k++) chars.push_back(ENT_TEXT[e][k]);
          if ($urandom_range(0, 3) != 0) chars.push_back(text_char());
        end
        4: begin
          chars.push_back(CH_AMP);
          chars.push_back(8'($urandom_range(0, 255)));
        end
        default: chars.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    mode = $urandom_range(0, 3);
    if (mode == 0) chars.push_back(stop_char());
    if (chars.size() == 0) chars.push_back(text_char());
    foreach (chars[i])
      add_byte(chars[i], i == 0, (mode == 1 || mode == 2) && i == chars.size() - 1);
  endfunction

  task send_item(xed_in_t t);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.decode_byte(t);
  endtask

  task send_feed();
    while (feed_q.size() != 0) send_item(feed_q.pop_front());
    in_valid <= 1'b0;
  endtask

  task wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_limit(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.out_limit = v;
  endtask

  task run_phase(logic [15:0] lim, int n_items, bit fast_tx, bit fast_rx, bit hold);
    wait_idle();
    write_limit(lim);
    tx_fast = fast_tx;
    rx_fast = fast_rx;
    long_hold = hold;
    while (feed_q.size() < n_items) build_string();
    send_feed();
  endtask

  always begin
    int stall;
    if (long_hold) begin
      out_ready <= 1'b0;
      repeat (150) @(posedge clk);
      long_hold = 0;
    end else begin
      stall = rx_fast ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (out_valid !== 1'b1);
    sb.check_output(out_data);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_byte("z", 1'b0, 1'b0);
    add_text("\"&apos", 1'b1);
    add_text("&lt;", 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(CH_GT, 1'b0, 1'b0);
    add_text("'&amp;&quo", 1'b0);
    add_byte("a", 1'b1, 1'b0);
    add_byte(CH_AMP, 1'b0, 1'b1);
    add_byte(CH_NUL, 1'b1, 1'b0);
    send_feed();

    run_phase(16'd1, 30, 1'b0, 1'b0, 1'b0);
    run_phase(16'd65535, 40, 1'b1, 1'b1, 1'b0);
    run_phase(16'd3, 35, 1'b0, 1'b1, 1'b0);
    run_phase(LIMIT_RST, 45, 1'b1, 1'b0, 1'b1);
    run_phase(16'd2, 30, 1'b1, 1'b0, 1'b0);
    run_phase(16'd8, 40, 1'b0, 1'b0, 1'b0);
    run_phase(16'($urandom_range(4, 24)), 40, 1'b0, 1'b1, 1'b0);
    run_phase(16'd5, 40, 1'b1, 1'b1, 1'b0);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/xed_pkg.sv
hw/rtl/xed_decode.sv
hw/rtl/xed_res_buf.sv
hw/rtl/xml_entity_decoder_top.sv
bench/xml_entity_decoder_top_test.sv
